### hw/rtl/integer_ratio_audio_resampler_defines.svh
// Assertion macros for the integer ratio audio resampler.
// Used by the top level only; no other dependencies.
`ifndef INTEGER_RATIO_AUDIO_RESAMPLER_DEFINES_SVH
`define INTEGER_RATIO_AUDIO_RESAMPLER_DEFINES_SVH

// same-cycle implication
`define IRAR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define IRAR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hw/rtl/irar_pkg.sv
// Package for the integer ratio audio resampler: types, constants and
// sample helper functions. No dependencies.
`timescale 1ns / 1ps

package irar_pkg;

   localparam int MAX_FACTOR = 16;
   localparam int FACTOR_W   = $clog2(MAX_FACTOR + 1);
   localparam int COUNT_W    = $clog2(MAX_FACTOR);
   localparam int RAW_W      = 16;
   localparam int CSR_DATA_W = 5;

   typedef logic signed [RAW_W-1:0] sample_type;
   typedef logic [FACTOR_W-1:0]     factor_type;
   typedef logic [COUNT_W-1:0]      count_type;

   typedef enum logic [1:0] {
      REG_WIDE_SAMPLES = 2'd0,
      REG_TWO_CHANNELS = 2'd1,
      REG_REDUCE_RATE  = 2'd2,
      REG_RATE_FACTOR  = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic       wide_samples;
      logic       two_channels;
      logic       reduce_rate;
      factor_type rate_factor;
   } cfg_type;

   typedef struct packed {
      sample_type prev_left;
      sample_type prev_right;
      count_type  skip;
   } hist_type;

   typedef struct packed {
      logic       produce;
      sample_type left;
      sample_type right;
      count_type  count;
      hist_type   hist;
   } calc_type;

   function automatic sample_type to_sample(input logic [RAW_W-1:0] raw, input logic wide);
      sample_type v;
      if (wide) begin
         v = sample_type'(raw);
      end else begin
         v = sample_type'({{(RAW_W-8){~raw[7]}}, ~raw[7], raw[6:0]});
      end
      return v;
   endfunction

   function automatic sample_type average(input sample_type a, input sample_type b);
      logic signed [RAW_W:0] s;
      s = {a[RAW_W-1], a} + {b[RAW_W-1], b};
      return sample_type'(s[RAW_W:1]);
   endfunction

   function automatic factor_type eff_factor(input factor_type f);
      factor_type v;
      if (f == '0) begin
         v = factor_type'(1);
      end else if (f > factor_type'(MAX_FACTOR)) begin
         v = factor_type'(MAX_FACTOR);
      end else begin
         v = f;
      end
      return v;
   endfunction

endpackage

### hw/rtl/integer_ratio_audio_resampler.sv
// Integer ratio resampler with an input register and a result register.
// Throughput: one frame per cycle for pass-through and downsampling while the
// result side is not back-pressured; when upsampling each frame holds the result
// register for the effective rate_factor beats, set by the repeat counter there.
// Synchronous reset clears valids, history, skip count and restores config.
`timescale 1ns / 1ps
`include "integer_ratio_audio_resampler_defines.svh"

module integer_ratio_audio_resampler
   import irar_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [RAW_W-1:0]         req_left_raw,
   input  logic [RAW_W-1:0]         req_right_raw,
   input  logic                     req_start_of_buffer,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [RAW_W-1:0]  rsp_left_out,
   output logic signed [RAW_W-1:0]  rsp_right_out,
   output logic                     rsp_last_of_run
);

   cfg_type          cfg_ff, cfg_in;
   hist_type         hist_ff, hist_in;
   logic             s1_valid_ff, s1_valid_in;
   logic [RAW_W-1:0] s1_left_ff, s1_right_ff;
   logic             s1_start_ff;
   logic             s2_valid_ff, s2_valid_in;
   sample_type       s2_left_ff, s2_right_ff;
   count_type        s2_count_ff, s2_count_in;
   calc_type         calc;
   logic             out_done;
   logic             s2_free;
   logic             s1_adv;
   logic             req_take;

   irar_calc u_calc (
      .cfg             (cfg_ff),
      .hist            (hist_ff),
      .left_raw        (s1_left_ff),
      .right_raw       (s1_right_ff),
      .start_of_buffer (s1_start_ff),
      .calc            (calc)
   );

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_WIDE_SAMPLES: cfg_in.wide_samples = csr_data[0];
            REG_TWO_CHANNELS: cfg_in.two_channels = csr_data[0];
            REG_REDUCE_RATE:  cfg_in.reduce_rate  = csr_data[0];
            REG_RATE_FACTOR:  cfg_in.rate_factor  = factor_type'(csr_data);
         endcase
      end
   end

   always_comb begin
      out_done    = s2_valid_ff && rsp_ready && (s2_count_ff == '0);
      s2_free     = !s2_valid_ff || out_done;
      s1_adv      = s1_valid_ff && (s2_free || !calc.produce);
      req_ready   = !s1_valid_ff || s1_adv;
      req_take    = req_valid && req_ready;
      s1_valid_in = req_take || (s1_valid_ff && !s1_adv);
      hist_in     = s1_adv ? calc.hist : hist_ff;

      s2_valid_in = s2_valid_ff && !out_done;
      s2_count_in = s2_count_ff;
      if (s2_valid_ff && rsp_ready && (s2_count_ff != '0)) begin
         s2_count_in = s2_count_ff - count_type'(1);
      end
      if (s1_adv && calc.produce) begin
         s2_valid_in = 1'b1;
         s2_count_in = calc.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= '{wide_samples: 1'b1, two_channels: 1'b1, reduce_rate: 1'b0,
                          rate_factor: factor_type'(1)};
         hist_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s2_count_ff <= '0;
      end else begin
         cfg_ff      <= cfg_in;
         hist_ff     <= hist_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s2_count_ff <= s2_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_left_ff  <= req_left_raw;
         s1_right_ff <= req_right_raw;
         s1_start_ff <= req_start_of_buffer;
      end
      if (s1_adv && calc.produce) begin
         s2_left_ff  <= calc.left;
         s2_right_ff <= calc.right;
      end
   end

   assign rsp_valid       = s2_valid_ff;
   assign rsp_left_out    = s2_left_ff;
   assign rsp_right_out   = s2_right_ff;
   assign rsp_last_of_run = (s2_count_ff == '0);

   `IRAR_ASSERT_NEXT(a_req_lands, clock, reset, req_valid && req_ready, s1_valid_ff)
   `IRAR_ASSERT_NOW(a_mono_right_zero, clock, reset, rsp_valid && !cfg_ff.two_channels, rsp_right_out == '0)
   `IRAR_ASSERT_NOW(a_count_bound, clock, reset, s2_valid_ff, factor_type'(s2_count_ff) < eff_factor(cfg_ff.rate_factor))

endmodule

### hw/rtl/irar_calc.sv
// Per-frame datapath: sample conversion, averaging, skip count, repeat count and history.
// Depends on irar_pkg.
`timescale 1ns / 1ps

module irar_calc
   import irar_pkg::*;
(
   input  cfg_type              cfg,
   input  hist_type             hist,
   input  logic [RAW_W-1:0]     left_raw,
   input  logic [RAW_W-1:0]     right_raw,
   input  logic                 start_of_buffer,
   output calc_type             calc
);

   sample_type            cur_l;
   sample_type            cur_r;
   sample_type            base_l;
   sample_type            base_r;
   count_type             skip_base;
   logic [COUNT_W:0]      skip_next;
   factor_type            f_eff;
   logic                  pass;

   always_comb begin
      f_eff     = eff_factor(cfg.rate_factor);
      pass      = (f_eff == factor_type'(1));
      cur_l     = to_sample(left_raw, cfg.wide_samples);
      cur_r     = cfg.two_channels ? to_sample(right_raw, cfg.wide_samples) : '0;
      base_l    = start_of_buffer ? cur_l : hist.prev_left;
      base_r    = (start_of_buffer && cfg.two_channels) ? cur_r : hist.prev_right;
      skip_base = start_of_buffer ? '0 : hist.skip;
      skip_next = {1'b0, skip_base} + (COUNT_W+1)'(1);

      calc.produce = 1'b1;
      calc.count   = '0;
      calc.hist.skip = skip_base;
      if (pass) begin
         calc.left  = cur_l;
         calc.right = cur_r;
      end else begin
         calc.left  = average(cur_l, base_l);
         calc.right = cfg.two_channels ? average(cur_r, base_r) : '0;
         if (cfg.reduce_rate) begin
            calc.produce   = (skip_base == '0);
            calc.hist.skip = ((FACTOR_W)'(skip_next) >= f_eff) ? '0 : skip_next[COUNT_W-1:0];
         end else begin
            calc.count = count_type'(f_eff - factor_type'(1));
         end
      end

      calc.hist.prev_left  = calc.produce ? cur_l : hist.prev_left;
      calc.hist.prev_right = (calc.produce && cfg.two_channels) ? cur_r : hist.prev_right;
   end

endmodule

### sim/testbench.sv
// Self-checking bench for integer_ratio_audio_resampler: directed frames, then random
// phases of settings and frames, against an in-bench model of the averaging resampler.
// Depends on irar_pkg and the resampler RTL only.
`timescale 1ns / 1ps

module testbench;
   import irar_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 8;
   localparam int RANDOM_FRAMES   = 296;

   class resampler_tracker;
      typedef struct {
         sample_type left;
         sample_type right;
         logic       last;
      } resampled_beat_type;

      resampled_beat_type due_beats[$];
      int failures;

      logic       wide;
      logic       stereo;
      logic       reduce;
      factor_type factor;
      sample_type hist_left;
      sample_type hist_right;
      int         skip_phase;

      function new();
         failures   = 0;
         wide       = 1'b1;
         stereo     = 1'b1;
         reduce     = 1'b0;
         factor     = factor_type'(1);
         hist_left  = '0;
         hist_right = '0;
         skip_phase = 0;
      endfunction

      function void set_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_WIDE_SAMPLES: wide   = data[0];
            REG_TWO_CHANNELS: stereo = data[0];
            REG_REDUCE_RATE:  reduce = data[0];
            REG_RATE_FACTOR:  factor = factor_type'(data);
            default: ;
         endcase
      endfunction

      function sample_type widen(logic [RAW_W-1:0] raw);
         if (wide) return sample_type'(raw);
         return sample_type'(int'(raw[7:0]) - 128);
      endfunction

      function sample_type mean2(sample_type a, sample_type b);
         int sum;
         sum = int'(a) + int'(b);
         return sample_type'(sum >>> 1);
      endfunction

      function void take_frame(logic [RAW_W-1:0] left_raw, logic [RAW_W-1:0] right_raw,
                               logic start);
         sample_type cur_left, cur_right, out_left, out_right;
         int         f, n;
         bit         take;
         cur_left  = widen(left_raw);
         cur_right = stereo ? widen(right_raw) : sample_type'(0);
         f = int'(factor);
         if (f == 0) f = 1;
         if (f > MAX_FACTOR) f = MAX_FACTOR;
         if (start) begin
            hist_left = cur_left;
            if (stereo) hist_right = cur_right;
            skip_phase = 0;
         end
         if (f == 1) begin
            out_left  = cur_left;
            out_right = cur_right;
            n = 1;
         end else begin
            if (reduce) begin
               take = (skip_phase == 0);
               skip_phase = (skip_phase + 1 >= f) ? 0 : skip_phase + 1;
               if (!take) return;
               n = 1;
            end else begin
               n = f;
            end
            out_left  = mean2(cur_left, hist_left);
            out_right = stereo ? mean2(cur_right, hist_right) : sample_type'(0);
         end
         hist_left = cur_left;
         if (stereo) hist_right = cur_right;
         for (int k = 0; k < n; k++) begin
            due_beats.push_back('{out_left, out_right, (k == n - 1)});
         end
      endfunction

      function void match_output(sample_type left, sample_type right, logic last);
         resampled_beat_type want;
         if (due_beats.size() == 0) begin
            $error("unexpected result beat: left_out %0d right_out %0d", left, right);
            failures++;
            return;
         end
         want = due_beats.pop_front();
         if (want.left !== left) begin
            $error("left_out: expected %0d, actual %0d", want.left, left);
            failures++;
         end
         if (want.right !== right) begin
            $error("right_out: expected %0d, actual %0d", want.right, right);
            failures++;
         end
         if (want.last !== last) begin
            $error("last_of_run: expected %0b, actual %0b", want.last, last);
            failures++;
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [1:0]              csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;
   logic                    req_valid;
   logic                    req_ready;
   logic [RAW_W-1:0]        req_left_raw;
   logic [RAW_W-1:0]        req_right_raw;
   logic                    req_start_of_buffer;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [RAW_W-1:0] rsp_left_out;
   logic signed [RAW_W-1:0] rsp_right_out;
   logic                    rsp_last_of_run;

   resampler_tracker tracker = new();
   bit gaps_on;
   bit hold_off_pending;
   int frames_sent;
   int cycles;

   integer_ratio_audio_resampler u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_left_raw        (req_left_raw),
      .req_right_raw       (req_right_raw),
      .req_start_of_buffer (req_start_of_buffer),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_left_out        (rsp_left_out),
      .rsp_right_out       (rsp_right_out),
      .rsp_last_of_run     (rsp_last_of_run)
   );

   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      csr_valid           = 1'b0;
      csr_index           = REG_WIDE_SAMPLES;
      csr_data            = '0;
      req_valid           = 1'b0;
      req_left_raw        = '0;
      req_right_raw       = '0;
      req_start_of_buffer = 1'b0;
      rsp_ready           = 1'b0;
      gaps_on             = 1'b1;
      hold_off_pending    = 1'b0;
      frames_sent         = 0;
      cycles              = 0;
   end

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // result sink: random back-pressure, one long hold-off on request
   initial begin : result_sink
      int gap;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            gap = HOLD_OFF_CYCLES;
         end else begin
            gap = gaps_on ? $urandom_range(0, 8) : 0;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         tracker.match_output(rsp_left_out, rsp_right_out, rsp_last_of_run);
      end
   end

   task automatic write_reg(input reg_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      tracker.set_reg(idx, data);
   endtask

   task automatic set_config(input bit wide, input bit stereo, input bit reduce,
                             input logic [CSR_DATA_W-1:0] factor);
      write_reg(REG_WIDE_SAMPLES, CSR_DATA_W'(wide));
      write_reg(REG_TWO_CHANNELS, CSR_DATA_W'(stereo));
      write_reg(REG_REDUCE_RATE, CSR_DATA_W'(reduce));
      write_reg(REG_RATE_FACTOR, factor);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_frame(input logic [RAW_W-1:0] left_raw,
                             input logic [RAW_W-1:0] right_raw, input logic start);
      int gap;
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_left_raw        <= left_raw;
      req_right_raw       <= right_raw;
      req_start_of_buffer <= start;
      req_valid           <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      tracker.take_frame(left_raw, right_raw, start);
      frames_sent++;
   endtask

   // skipped frames give no beat, so linger past the last one before touching config
   task automatic finish_phase();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.due_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [RAW_W-1:0] pick_raw();
      case ($urandom_range(0, 11))
         0: return 16'h0000;
         1: return 16'h7FFF;
         2: return 16'h8000;
         3: return 16'hFFFF;
         4: return 16'h0080;
         5: return 16'hFF7F;
         default: return RAW_W'($urandom);
      endcase
   endfunction

   initial begin : main_flow
      int  phase;
      int  count;
      bit  wide, stereo, reduce;
      logic [CSR_DATA_W-1:0] factor;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: wide stereo pass-through
      send_frame(16'h7FFF, 16'h8000, 1'b1);
      send_frame(16'h8000, 16'h7FFF, 1'b0);
      send_frame(16'hFFFF, 16'h0000, 1'b0);
      finish_phase();

      set_config(1'b1, 1'b1, 1'b0, 5'd2);
      send_frame(16'h7FFF, 16'h7FFF, 1'b1);
      send_frame(16'h8000, 16'h8000, 1'b0);
      send_frame(16'h0001, 16'hFFFF, 1'b0);
      finish_phase();

      // narrow mono: high byte and right channel ignored
      set_config(1'b0, 1'b0, 1'b0, 5'd3);
      send_frame(16'h12FF, 16'hABCD, 1'b1);
      send_frame(16'hFF00, 16'h5555, 1'b0);
      send_frame(16'h0080, 16'hFFFF, 1'b0);
      finish_phase();

      // narrow stereo downsampling, start mid-count restarts it
      set_config(1'b0, 1'b1, 1'b1, 5'd3);
      send_frame(16'hA17F, 16'h5A80, 1'b1);
      send_frame(16'h00FF, 16'hFF00, 1'b0);
      send_frame(16'h0000, 16'h00FF, 1'b0);
      send_frame(16'h3C01, 16'hC3FE, 1'b0);
      send_frame(16'hFFFF, 16'h0000, 1'b1);
      send_frame(16'h0040, 16'h00C0, 1'b0);
      finish_phase();

      // factor zero acts as one
      set_config(1'b1, 1'b1, 1'b1, 5'd0);
      send_frame(16'h8000, 16'h7FFF, 1'b0);
      send_frame(16'h1234, 16'hEDCB, 1'b0);
      finish_phase();

      // oversized factor saturates, then shrinks past the skip count
      set_config(1'b1, 1'b1, 1'b1, 5'd31);
      send_frame(16'h4000, 16'hC000, 1'b1);
      send_frame(16'h1111, 16'h2222, 1'b0);
      send_frame(16'h3333, 16'h4444, 1'b0);
      finish_phase();
      set_config(1'b1, 1'b1, 1'b1, 5'd2);
      send_frame(16'h7FFF, 16'h8000, 1'b0);
      send_frame(16'h8000, 16'h7FFF, 1'b0);
      send_frame(16'h0002, 16'hFFFE, 1'b0);
      finish_phase();

      set_config(1'b1, 1'b0, 1'b0, 5'd17);
      send_frame(16'h8001, 16'h1234, 1'b1);
      finish_phase();

      phase = 0;
      while (frames_sent < 24 + RANDOM_FRAMES) begin
         wide   = $urandom_range(0, 1);
         stereo = $urandom_range(0, 1);
         reduce = $urandom_range(0, 1);
         case ($urandom_range(0, 7))
            0: factor = 5'd0;
            1: factor = 5'd1;
            2: factor = CSR_DATA_W'(MAX_FACTOR);
            3: factor = CSR_DATA_W'($urandom_range(MAX_FACTOR + 1, 31));
            default: factor = CSR_DATA_W'($urandom_range(2, 6));
         endcase
         count   = $urandom_range(10, 30);
         gaps_on = ($urandom_range(0, 3) != 0);
         if (phase == 1) begin
            reduce  = 1'b0;
            factor  = 5'd4;
            gaps_on = 1'b0;
            hold_off_pending = 1'b1;
         end
         set_config(wide, stereo, reduce, factor);
         for (int i = 0; i < count; i++) begin
            send_frame(pick_raw(), pick_raw(),
                       (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 15) == 0));
         end
         finish_phase();
         phase++;
      end

      if (tracker.failures == 0 && tracker.due_beats.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
